FILE: hw/rtl/sdtw_pkg.sv
// ----------------------------------------------------------------------------
// sdtw_pkg
// Field widths and operation/status codes of the spike delay timing wheel.
// ----------------------------------------------------------------------------
package sdtw_pkg;

  localparam int MODE_W    = 2;
  localparam int DELAY_W   = 6;
  localparam int NEURON_W  = 16;
  localparam int SYNAPSE_W = 10;
  localparam int STATUS_W  = 2;
  localparam int SCOUNT_W  = 7;

  localparam logic [SCOUNT_W-1:0] SLOT_COUNT_RESET = 7'd64;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADV = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DELAY = 2'd2;

endpackage

FILE: hw/rtl/sdtw_if.sv
// ----------------------------------------------------------------------------
// sdtw channel interfaces
// Valid/ready channels for operations, results and the slot count register.
// ----------------------------------------------------------------------------
interface sdtw_in_if;
  logic                           valid;
  logic                           ready;
  logic [sdtw_pkg::MODE_W-1:0]    mode;
  logic [sdtw_pkg::DELAY_W-1:0]   delay;
  logic [sdtw_pkg::NEURON_W-1:0]  neuron;
  logic [sdtw_pkg::SYNAPSE_W-1:0] synapse;

  modport source (output valid, mode, delay, neuron, synapse, input ready);
  modport sink   (input valid, mode, delay, neuron, synapse, output ready);
endinterface

interface sdtw_out_if;
  logic                           valid;
  logic                           ready;
  logic                           event_valid;
  logic [sdtw_pkg::NEURON_W-1:0]  out_neuron;
  logic [sdtw_pkg::SYNAPSE_W-1:0] out_synapse;
  logic                           slot_empty;
  logic [sdtw_pkg::STATUS_W-1:0]  status;

  modport source (output valid, event_valid, out_neuron, out_synapse, slot_empty, status,
                  input ready);
  modport sink   (input valid, event_valid, out_neuron, out_synapse, slot_empty, status,
                  output ready);
endinterface

interface sdtw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sdtw_pkg::SCOUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/sdtw_slot_mem.sv
// ----------------------------------------------------------------------------
// sdtw_slot_mem
// Per-slot {head, tail} memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module sdtw_slot_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 21
) (
  input  logic          clk,
  input  logic          w_en,
  input  logic [AW-1:0] w_addr,
  input  logic [DW-1:0] w_data,
  input  logic          ra_en,
  input  logic [AW-1:0] ra_addr,
  output logic [DW-1:0] ra_data,
  input  logic          rb_en,
  input  logic [AW-1:0] rb_addr,
  output logic [DW-1:0] rb_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (w_en) begin
      mem[w_addr] <= w_data;
    end
    if (ra_en) begin
      ra_data <= mem[ra_addr];
    end
    if (rb_en) begin
      rb_data <= mem[rb_addr];
    end
  end

endmodule

FILE: hw/rtl/sdtw_event_mem.sv
// ----------------------------------------------------------------------------
// sdtw_event_mem
// Event pool memory of {neuron, synapse, next}; the link field writes alone.
// ----------------------------------------------------------------------------
module sdtw_event_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int LW    = 11,
  parameter int DW    = 37
) (
  input  logic          clk,
  input  logic          w_en,
  input  logic          w_full,
  input  logic [AW-1:0] w_addr,
  input  logic [DW-1:0] w_data,
  input  logic          r_en,
  input  logic [AW-1:0] r_addr,
  output logic [DW-1:0] r_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (w_en) begin
      if (w_full) begin
        mem[w_addr] <= w_data;
      end else begin
        // relink only: keep the payload
        mem[w_addr][LW-1:0] <= w_data[LW-1:0];
      end
    end
    if (r_en) begin
      r_data <= mem[r_addr];
    end
  end

endmodule

FILE: hw/rtl/spike_delay_timing_wheel.sv
// ----------------------------------------------------------------------------
// spike_delay_timing_wheel
// Timing wheel of delayed spike events, linked lists over a fixed event pool.
// ----------------------------------------------------------------------------
//  channel   dir  transfer                     payload
//  in_if     in   one operation                mode, delay, neuron, synapse
//  out_if    out  one result per operation     event_valid, out_neuron,
//                                              out_synapse, slot_empty, status
//  cfg_if    in   slot count write             data (7 bits)
//
//  Add, advance, unused mode and a pop of an empty slot: the accept cycle
//  reads the slot memory, the read cycle (ST_RD) writes back. A pop of a
//  non-empty slot also passes ST_POP: the event memory read depends on the slot head.
//  After reset a clearing pass nulls every slot head; in_if is not ready
//  meanwhile, cfg_if is always ready.
//  The final cycle holds while the result register is still full.
// ----------------------------------------------------------------------------
module spike_delay_timing_wheel #(
  parameter int SLOTS = 64,
  parameter int POOL  = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  sdtw_in_if.sink      in_if,
  sdtw_out_if.source   out_if,
  sdtw_cfg_if.sink     cfg_if
);

  localparam int SW     = $clog2(SLOTS);
  localparam int PW     = $clog2(POOL);
  localparam int HW     = $clog2(POOL + 1);
  localparam int CW     = (SW + 2 > 8) ? SW + 2 : 8;
  localparam int SLOT_W = HW + PW;
  localparam int EV_W   = sdtw_pkg::NEURON_W + sdtw_pkg::SYNAPSE_W + HW;
  localparam logic [HW-1:0] NIL = HW'(POOL);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RD    = 4'b0100,
    ST_POP   = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [SW-1:0]                    clr_idx_r, clr_idx_nxt;
  logic [sdtw_pkg::SCOUNT_W-1:0]    slot_count_r, slot_count_nxt;
  logic [SW-1:0]                    cur_r, cur_nxt;
  logic [HW-1:0]                    fresh_r, fresh_nxt;
  logic [HW-1:0]                    rec_r, rec_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // operation held across its cycles
  logic [sdtw_pkg::MODE_W-1:0]      mode_r;
  logic [sdtw_pkg::NEURON_W-1:0]    neuron_r;
  logic [sdtw_pkg::SYNAPSE_W-1:0]   synapse_r;
  logic [SW-1:0]                    idx_r;
  logic [SW-1:0]                    cur_next_r;
  logic                             dly_bad_r;

  logic                             ev_valid_r, ev_valid_nxt;
  logic [sdtw_pkg::NEURON_W-1:0]    neuron_out_r, neuron_out_nxt;
  logic [sdtw_pkg::SYNAPSE_W-1:0]   synapse_out_r, synapse_out_nxt;
  logic                             empty_r, empty_nxt;
  logic [sdtw_pkg::STATUS_W-1:0]    status_r, status_nxt;

  logic                             in_acc, out_free, finish;
  logic [CW-1:0]                    count_c, sum_c, inc_c, nxt_c;
  logic [SW-1:0]                    idx_c;
  logic                             dly_bad_c;

  logic                             sm_w_en, sm_ra_en, sm_rb_en;
  logic [SW-1:0]                    sm_w_addr, sm_ra_addr, sm_rb_addr;
  logic [SLOT_W-1:0]                sm_w_data, sm_ra_data, sm_rb_data;
  logic                             em_w_en, em_w_full, em_r_en;
  logic [PW-1:0]                    em_w_addr, em_r_addr;
  logic [EV_W-1:0]                  em_w_data, em_r_data;

  logic [HW-1:0]                    head_a, head_b, ev_next;
  logic [PW-1:0]                    tail_a, alloc_e;
  logic                             alloc;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  assign head_a  = sm_ra_data[PW +: HW];
  assign tail_a  = sm_ra_data[PW-1:0];
  assign head_b  = sm_rb_data[PW +: HW];
  assign ev_next = em_r_data[HW-1:0];

  // effective slot count, clamped to [1, SLOTS]
  always_comb begin
    if (slot_count_r == '0) begin
      count_c = CW'(1);
    end else if (CW'(slot_count_r) > CW'(SLOTS)) begin
      count_c = CW'(SLOTS);
    end else begin
      count_c = CW'(slot_count_r);
    end
  end

  assign dly_bad_c = CW'(in_if.delay) >= count_c;
  assign sum_c     = CW'(cur_r) + CW'(in_if.delay);
  assign idx_c     = (sum_c >= count_c) ? SW'(sum_c - count_c) : SW'(sum_c);
  assign inc_c     = CW'(cur_r) + CW'(1);
  assign nxt_c     = (inc_c >= count_c) ? '0 : inc_c;

  // read issue
  always_comb begin
    sm_ra_en   = in_acc;
    sm_rb_en   = in_acc;
    sm_ra_addr = (in_if.mode == sdtw_pkg::MODE_ADD) ? idx_c : cur_r;
    sm_rb_addr = (in_if.mode == sdtw_pkg::MODE_ADV) ? nxt_c[SW-1:0] : cur_r;
    if (state_r == ST_RD) begin
      em_r_en   = (mode_r == sdtw_pkg::MODE_POP) && (head_a != NIL);
      em_r_addr = head_a[PW-1:0];
    end else begin
      em_r_en   = in_acc;
      em_r_addr = rec_r[PW-1:0];
    end
  end

  // allocation for add: recycled list first, then fresh entries
  always_comb begin
    alloc   = 1'b0;
    alloc_e = rec_r[PW-1:0];
    if (!dly_bad_r) begin
      if (rec_r != NIL) begin
        alloc = 1'b1;
      end else if (fresh_r != NIL) begin
        alloc   = 1'b1;
        alloc_e = fresh_r[PW-1:0];
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    slot_count_nxt  = slot_count_r;
    cur_nxt         = cur_r;
    fresh_nxt       = fresh_r;
    rec_nxt         = rec_r;
    finish          = 1'b0;
    ev_valid_nxt    = 1'b0;
    neuron_out_nxt  = '0;
    synapse_out_nxt = '0;
    empty_nxt       = empty_r;
    status_nxt      = sdtw_pkg::STATUS_OK;
    sm_w_en         = 1'b0;
    sm_w_addr       = cur_r;
    sm_w_data       = {NIL, tail_a};
    em_w_en         = 1'b0;
    em_w_full       = 1'b0;
    em_w_addr       = tail_a;
    em_w_data       = {neuron_r, synapse_r, rec_r};

    if (cfg_if.valid && cfg_if.ready) begin
      slot_count_nxt = cfg_if.data;
    end

    case (state_r)
      ST_CLEAR: begin
        sm_w_en   = 1'b1;
        sm_w_addr = clr_idx_r;
        sm_w_data = {NIL, PW'(0)};
        clr_idx_nxt = SW'(clr_idx_r + SW'(1));
        if (clr_idx_r == SW'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        case (mode_r)
          sdtw_pkg::MODE_ADD: begin
            if (out_free) begin
              finish = 1'b1;
              if (dly_bad_r) begin
                status_nxt = sdtw_pkg::STATUS_DELAY;
              end else if (!alloc) begin
                status_nxt = sdtw_pkg::STATUS_FULL;
              end
              if (alloc) begin
                if (rec_r != NIL) begin
                  rec_nxt = ev_next;
                end else begin
                  fresh_nxt = HW'(fresh_r + HW'(1));
                end
                em_w_en   = 1'b1;
                em_w_full = 1'b1;
                em_w_addr = alloc_e;
                em_w_data = {neuron_r, synapse_r, head_a};
                sm_w_en   = 1'b1;
                sm_w_addr = idx_r;
                sm_w_data = {HW'(alloc_e), (head_a == NIL) ? alloc_e : tail_a};
              end
              empty_nxt = (alloc && idx_r == cur_r) ? 1'b0 : (head_b == NIL);
            end
          end
          sdtw_pkg::MODE_POP: begin
            if (head_a != NIL) begin
              state_nxt = ST_POP;
            end else if (out_free) begin
              finish    = 1'b1;
              empty_nxt = 1'b1;
            end
          end
          sdtw_pkg::MODE_ADV: begin
            if (out_free) begin
              finish = 1'b1;
              if (head_a != NIL) begin
                // splice the rest of the slot onto the recycled list
                em_w_en   = 1'b1;
                em_w_addr = tail_a;
                em_w_data = {neuron_r, synapse_r, rec_r};
                rec_nxt   = head_a;
                sm_w_en   = 1'b1;
                sm_w_addr = cur_r;
                sm_w_data = {NIL, tail_a};
              end
              cur_nxt   = cur_next_r;
              empty_nxt = (cur_next_r == cur_r) ? 1'b1 : (head_b == NIL);
            end
          end
          default: begin
            if (out_free) begin
              finish    = 1'b1;
              empty_nxt = (head_a == NIL);
            end
          end
        endcase
      end
      ST_POP: begin
        if (out_free) begin
          finish          = 1'b1;
          ev_valid_nxt    = 1'b1;
          neuron_out_nxt  = em_r_data[EV_W-1 -: sdtw_pkg::NEURON_W];
          synapse_out_nxt = em_r_data[HW +: sdtw_pkg::SYNAPSE_W];
          empty_nxt       = (ev_next == NIL);
          sm_w_en         = 1'b1;
          sm_w_addr       = cur_r;
          sm_w_data       = {ev_next, tail_a};
          em_w_en         = 1'b1;
          em_w_addr       = head_a[PW-1:0];
          em_w_data       = {neuron_r, synapse_r, rec_r};
          rec_nxt         = head_a;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    if (finish) begin
      state_nxt = ST_IDLE;
    end

    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      slot_count_r <= sdtw_pkg::SLOT_COUNT_RESET;
      cur_r        <= '0;
      fresh_r      <= '0;
      rec_r        <= NIL;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      slot_count_r <= slot_count_nxt;
      cur_r        <= cur_nxt;
      fresh_r      <= fresh_nxt;
      rec_r        <= rec_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r     <= in_if.mode;
      neuron_r   <= in_if.neuron;
      synapse_r  <= in_if.synapse;
      idx_r      <= idx_c;
      cur_next_r <= nxt_c[SW-1:0];
      dly_bad_r  <= dly_bad_c;
    end
    if (finish) begin
      ev_valid_r    <= ev_valid_nxt;
      neuron_out_r  <= neuron_out_nxt;
      synapse_out_r <= synapse_out_nxt;
      empty_r       <= empty_nxt;
      status_r      <= status_nxt;
    end
  end

  sdtw_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (SW),
    .DW    (SLOT_W)
  ) u_slot_mem (
    .clk     (clk),
    .w_en    (sm_w_en),
    .w_addr  (sm_w_addr),
    .w_data  (sm_w_data),
    .ra_en   (sm_ra_en),
    .ra_addr (sm_ra_addr),
    .ra_data (sm_ra_data),
    .rb_en   (sm_rb_en),
    .rb_addr (sm_rb_addr),
    .rb_data (sm_rb_data)
  );

  sdtw_event_mem #(
    .DEPTH (POOL),
    .AW    (PW),
    .LW    (HW),
    .DW    (EV_W)
  ) u_event_mem (
    .clk    (clk),
    .w_en   (em_w_en),
    .w_full (em_w_full),
    .w_addr (em_w_addr),
    .w_data (em_w_data),
    .r_en   (em_r_en),
    .r_addr (em_r_addr),
    .r_data (em_r_data)
  );

  assign in_if.ready        = (state_r == ST_IDLE);
  assign cfg_if.ready       = 1'b1;
  assign out_if.valid       = out_valid_r;
  assign out_if.event_valid = ev_valid_r;
  assign out_if.out_neuron  = neuron_out_r;
  assign out_if.out_synapse = synapse_out_r;
  assign out_if.slot_empty  = empty_r;
  assign out_if.status      = status_r;

  // a recycled entry must have come from the fresh range
  a_rec_from_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_r != NIL) |-> (fresh_r != '0))
    else $error("recycled list non-empty with no entries handed out");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= NIL)
    else $error("fresh count beyond pool size");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RD))
    else $error("accepted operation did not enter the read cycle");

  a_drop_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != sdtw_pkg::STATUS_OK) |-> !ev_valid_r)
    else $error("dropped add reports an event");

  a_pop_from_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> ($past(state_r) == ST_RD || $past(state_r) == ST_POP))
    else $error("pop link cycle entered out of sequence");

endmodule
